[rtl/core/hbc_pkg.sv]
// ----------------------------------------------------------------------------
// hbc_pkg
// Shared widths, codes and reset values of the 2D Hilbert curve codec.
// ----------------------------------------------------------------------------
package hbc_pkg;

    localparam int ORDER_W  = 6;
    localparam int COORD_W  = 32;
    localparam int INDEX_W  = 64;

    localparam int MAX_ORDER_DEF = 32;

    // s_tdata: coord_x, coord_y, curve_index
    localparam int S_DATA_W = 2 * COORD_W + INDEX_W;
    // m_tdata: index_out, x_out, y_out
    localparam int M_DATA_W = INDEX_W + 2 * COORD_W;

    localparam logic FUNC_ENCODE = 1'b0;
    localparam logic FUNC_DECODE = 1'b1;

    localparam logic [ORDER_W-1:0] CURVE_ORDER_RST = 6'd16;

endpackage

[rtl/core/hilbert_2d_codec_core.sv]
// ----------------------------------------------------------------------------
// hilbert_2d_codec_core
// Two-stage stream codec between 2D grid cells and Hilbert curve indices.
// ----------------------------------------------------------------------------
// One item per clock while m_tready is high: an input register feeds the
// encode and decode logic, whose result is caught in an output register.
// While a result waits on m_tready, the input side takes a beat only if
// the input register is empty. curve_order (reset 16) sets the number of
// levels; 0 or above MAX_ORDER returns order_error with all data zero.
// Write curve_order only while no beat is in flight.
module hilbert_2d_codec_core
    import hbc_pkg::*;
#(
    parameter int MAX_ORDER = MAX_ORDER_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [ORDER_W-1:0]  cfg_data,   // curve_order

    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,    // coord_x, coord_y, curve_index
    input  logic                s_tuser,    // func

    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,    // index_out, x_out, y_out
    output logic                m_tuser     // order_error
);

    logic [ORDER_W-1:0]  curve_order_reg, curve_order_next;

    logic                in_valid_reg, in_valid_next;
    logic                in_func_reg, in_func_next;
    logic [COORD_W-1:0]  in_x_reg, in_x_next;
    logic [COORD_W-1:0]  in_y_reg, in_y_next;
    logic [INDEX_W-1:0]  in_idx_reg, in_idx_next;

    logic                out_valid_reg, out_valid_next;
    logic [M_DATA_W-1:0] out_data_reg, out_data_next;
    logic                out_err_reg, out_err_next;

    logic                out_adv;
    logic                in_adv;
    logic                order_bad;
    logic [INDEX_W-1:0]  enc_index;
    logic [COORD_W-1:0]  dec_x;
    logic [COORD_W-1:0]  dec_y;
    logic [INDEX_W-1:0]  res_index;
    logic [COORD_W-1:0]  res_x;
    logic [COORD_W-1:0]  res_y;

    hbc_encode #(.MAX_ORDER(MAX_ORDER)) u_encode (
        .coord_x   (in_x_reg),
        .coord_y   (in_y_reg),
        .order     (curve_order_reg),
        .index_out (enc_index)
    );

    hbc_decode #(.MAX_ORDER(MAX_ORDER)) u_decode (
        .curve_index (in_idx_reg),
        .order       (curve_order_reg),
        .x_out       (dec_x),
        .y_out       (dec_y)
    );

    assign out_adv   = !out_valid_reg || m_tready;
    assign in_adv    = !in_valid_reg || out_adv;
    assign order_bad = (curve_order_reg == '0) ||
                       (curve_order_reg > ORDER_W'(MAX_ORDER));

    assign res_index = (!order_bad && in_func_reg == FUNC_ENCODE) ? enc_index : '0;
    assign res_x     = (!order_bad && in_func_reg == FUNC_DECODE) ? dec_x : '0;
    assign res_y     = (!order_bad && in_func_reg == FUNC_DECODE) ? dec_y : '0;

    always_comb begin
        curve_order_next = curve_order_reg;
        in_valid_next    = in_valid_reg;
        in_func_next     = in_func_reg;
        in_x_next        = in_x_reg;
        in_y_next        = in_y_reg;
        in_idx_next      = in_idx_reg;
        out_valid_next   = out_valid_reg;
        out_data_next    = out_data_reg;
        out_err_next     = out_err_reg;

        if (cfg_valid) begin
            curve_order_next = cfg_data;
        end

        if (in_adv) begin
            in_valid_next = s_tvalid;
            if (s_tvalid) begin
                in_func_next = s_tuser;
                in_x_next    = s_tdata[COORD_W-1:0];
                in_y_next    = s_tdata[2*COORD_W-1:COORD_W];
                in_idx_next  = s_tdata[S_DATA_W-1:2*COORD_W];
            end
        end

        if (out_adv) begin
            out_valid_next = in_valid_reg;
            if (in_valid_reg) begin
                out_data_next = {res_y, res_x, res_index};
                out_err_next  = order_bad;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            curve_order_reg <= CURVE_ORDER_RST;
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            curve_order_reg <= curve_order_next;
            in_valid_reg    <= in_valid_next;
            out_valid_reg   <= out_valid_next;
        end
        in_func_reg  <= in_func_next;
        in_x_reg     <= in_x_next;
        in_y_reg     <= in_y_next;
        in_idx_reg   <= in_idx_next;
        out_data_reg <= out_data_next;
        out_err_reg  <= out_err_next;
    end

    assign cfg_ready = 1'b1;
    assign s_tready  = in_adv;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tuser   = out_err_reg;

endmodule

[rtl/core/hbc_encode.sv]
// ----------------------------------------------------------------------------
// hbc_encode
// Cell (x, y) to Hilbert index, walked from the top level down.
// ----------------------------------------------------------------------------
module hbc_encode
    import hbc_pkg::*;
#(
    parameter int MAX_ORDER = MAX_ORDER_DEF
) (
    input  logic [COORD_W-1:0] coord_x,
    input  logic [COORD_W-1:0] coord_y,
    input  logic [ORDER_W-1:0] order,
    output logic [INDEX_W-1:0] index_out
);

    // Reflect/swap ops form a commutative group, so the pending transform
    // of the lower bits is just two flags: swap and complement.
    logic [MAX_ORDER:0]     swp;
    logic [MAX_ORDER:0]     neg;
    logic [MAX_ORDER-1:0]   act;
    logic [MAX_ORDER-1:0]   bx;
    logic [MAX_ORDER-1:0]   by;
    logic [2*MAX_ORDER-1:0] quad;

    assign swp[MAX_ORDER] = 1'b0;
    assign neg[MAX_ORDER] = 1'b0;

    for (genvar l = 0; l < MAX_ORDER; l++) begin : g_lvl
        assign act[l] = (ORDER_W'(l) < order);
        assign bx[l]  = (swp[l+1] ? coord_y[l] : coord_x[l]) ^ neg[l+1];
        assign by[l]  = (swp[l+1] ? coord_x[l] : coord_y[l]) ^ neg[l+1];

        assign swp[l] = swp[l+1] ^ (act[l] & ~by[l]);
        assign neg[l] = neg[l+1] ^ (act[l] & ~by[l] & bx[l]);

        assign quad[2*l+1] = act[l] & bx[l];
        assign quad[2*l]   = act[l] & (bx[l] ^ by[l]);
    end

    assign index_out = INDEX_W'(quad);

endmodule

[rtl/core/hbc_decode.sv]
// ----------------------------------------------------------------------------
// hbc_decode
// Hilbert index to cell (x, y); each level's bits take the transform of all
// levels above it.
// ----------------------------------------------------------------------------
module hbc_decode
    import hbc_pkg::*;
#(
    parameter int MAX_ORDER = MAX_ORDER_DEF
) (
    input  logic [INDEX_W-1:0] curve_index,
    input  logic [ORDER_W-1:0] order,
    output logic [COORD_W-1:0] x_out,
    output logic [COORD_W-1:0] y_out
);

    logic [MAX_ORDER-1:0] act;
    logic [MAX_ORDER-1:0] bx;
    logic [MAX_ORDER-1:0] by;
    logic [MAX_ORDER-1:0] op_swp;
    logic [MAX_ORDER-1:0] op_neg;
    logic [MAX_ORDER-1:0] sfx_swp;
    logic [MAX_ORDER-1:0] sfx_neg;
    logic [MAX_ORDER-1:0] xb;
    logic [MAX_ORDER-1:0] yb;

    for (genvar l = 0; l < MAX_ORDER; l++) begin : g_lvl
        localparam logic [MAX_ORDER-1:0] HiMask =
            ~(MAX_ORDER'((64'd1 << (l + 1)) - 64'd1));

        assign act[l]    = (ORDER_W'(l) < order);
        assign bx[l]     = act[l] & curve_index[2*l+1];
        assign by[l]     = act[l] & (curve_index[2*l] ^ curve_index[2*l+1]);
        assign op_swp[l] = act[l] & ~by[l];
        assign op_neg[l] = act[l] & ~by[l] & bx[l];

        // parity of the ops of all higher levels
        assign sfx_swp[l] = ^(op_swp & HiMask);
        assign sfx_neg[l] = ^(op_neg & HiMask);

        assign xb[l] = (sfx_swp[l] ? by[l] : bx[l]) ^ sfx_neg[l];
        assign yb[l] = (sfx_swp[l] ? bx[l] : by[l]) ^ sfx_neg[l];
    end

    assign x_out = COORD_W'(xb);
    assign y_out = COORD_W'(yb);

endmodule
